// ===== rtl/aeat_pkg.sv =====
// shared types and constants for the absolute encoder angle tracker
package aeat_pkg;

  localparam int POS_W    = 7;
  localparam int REL_W    = 16;
  localparam int DELTA_W  = 8;
  localparam int ANGLE_W  = 24;
  localparam int STEP_W   = 16;
  localparam int SCALE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // |delta| * step fits in 23 bits, times scale in 39 bits
  localparam int MAG_W  = 23;
  localparam int PROD_W = MAG_W + SCALE_W;
  localparam int CNT_W  = 6;
  localparam int REM_W  = 7;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  localparam logic [POS_W-1:0] WRAP_UP_OLD_MIN  = 7'd117;
  localparam logic [POS_W-1:0] WRAP_UP_NEW_MAX  = 7'd10;
  localparam logic [POS_W-1:0] WRAP_DN_OLD_MAX  = 7'd15;
  localparam logic [POS_W-1:0] WRAP_DN_NEW_MIN  = 7'd110;
  localparam logic [8:0]       POS_COUNT        = 9'd128;
  localparam logic [REM_W:0]   SCALE_DIVISOR    = 8'd100;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -24'sh800000;
  localparam logic [PROD_W-1:0] POS_LIMIT = 39'd8388607;
  localparam logic [PROD_W-1:0] NEG_LIMIT = 39'd8388608;

  localparam logic [STEP_W-1:0]  STEP_RST  = 16'd720;
  localparam logic [ANGLE_W-1:0] START_RST = 24'd0;
  localparam logic [ANGLE_W-1:0] STOP_RST  = 24'd92160;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd100;

  typedef enum logic [1:0] {
    MODE_ABS   = 2'd0,
    MODE_REL   = 2'd1,
    MODE_SCALE = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_MODE   = 3'd1,
    CFG_STEP   = 3'd2,
    CFG_START  = 3'd3,
    CFG_STOP   = 3'd4,
    CFG_SCALE  = 3'd5
  } cfg_idx_t;

endpackage

// ===== rtl/absolute_encoder_angle_tracker_core.sv =====
// angle tracker core: wrap-corrected delta, relative count, bit-serial angle math
// One position word in, one result word out. A word that is ignored (block
// disabled or position unchanged) or that arrives in mode 3 goes straight to
// the finish step, which loads the output register. Modes 0 and 1 run the
// bit-serial shift-add multiplier, then the saturate, accumulate, clamp and
// output steps. Mode 2 runs two multiplier passes (delta times step, then
// times scale) and a restoring divide by 100, one quotient bit per cycle,
// before those final steps. The next word is taken once the result has moved
// to the output register. Configuration writes are always ready and take
// effect at once; write them only while no word is in flight.
module absolute_encoder_angle_tracker_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aeat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aeat_pkg::CFG_DATA_W-1:0]      cfg_data,
  // position stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [aeat_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [6:0] position
  // result stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [6:0] absolute_out, [22:7] relative_out, [30:23] delta_out, [54:31] angle_out
  output logic [aeat_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tuser   // [0] changed
);
  import aeat_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_ACCUM,
    ST_CLAMP,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration
  logic                       enable;
  mode_t                      mode;
  logic [STEP_W-1:0]          step_angle;
  logic signed [ANGLE_W-1:0]  angle_lo;
  logic signed [ANGLE_W-1:0]  angle_hi;
  logic [SCALE_W-1:0]         scale_percent;

  // tracker state
  logic [POS_W-1:0]           last_position;
  logic signed [REL_W-1:0]    relative_count;
  logic signed [DELTA_W-1:0]  last_delta;
  logic signed [ANGLE_W-1:0]  angle_acc;
  logic                       changed;

  // serial datapath
  logic [MAG_W-1:0]           mul_a;
  logic [SCALE_W-1:0]         mul_b;
  logic [PROD_W-1:0]          acc;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic                       neg;
  logic                       pass2;
  logic signed [ANGLE_W-1:0]  inc;
  logic signed [ANGLE_W-1:0]  pre;

  // output register
  logic                       out_valid;
  logic [POS_W-1:0]           out_abs;
  logic [REL_W-1:0]           out_rel;
  logic [DELTA_W-1:0]         out_delta;
  logic [ANGLE_W-1:0]         out_angle;
  logic                       out_chg;

  logic                       in_fire;
  logic [POS_W-1:0]           pos;
  logic signed [8:0]          diff;
  logic signed [8:0]          diff_wrap;
  logic signed [DELTA_W-1:0]  delta_next;
  logic signed [REL_W-1:0]    relative_count_next;
  logic [MAG_W-1:0]           mag_start;
  logic                       neg_start;
  logic [PROD_W-1:0]          acc_next;
  logic [REM_W:0]             div_trial;
  logic                       div_ge;
  logic signed [ANGLE_W:0]    sum;
  logic signed [ANGLE_W-1:0]  sum_sat;
  logic signed [ANGLE_W-1:0]  clamp_lo;
  logic signed [ANGLE_W-1:0]  clamp_val;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pos           = s_axis_tdata[POS_W-1:0];

  // wrap-corrected step delta, always within -127..127
  always_comb begin
    diff = $signed({2'b00, pos}) - $signed({2'b00, last_position});
    if ((last_position > WRAP_UP_OLD_MIN) && (pos < WRAP_UP_NEW_MAX)) begin
      diff_wrap = diff + $signed(POS_COUNT);
    end else if ((last_position < WRAP_DN_OLD_MAX) && (pos > WRAP_DN_NEW_MIN)) begin
      diff_wrap = diff - $signed(POS_COUNT);
    end else begin
      diff_wrap = diff;
    end
    delta_next          = diff_wrap[DELTA_W-1:0];
    relative_count_next = relative_count + {{(REL_W-DELTA_W){delta_next[DELTA_W-1]}}, delta_next};
  end

  // multiplicand magnitude and sign for the first pass
  always_comb begin
    case (mode)
      MODE_ABS: begin
        mag_start = {{(MAG_W-POS_W){1'b0}}, pos};
        neg_start = 1'b0;
      end
      MODE_REL: begin
        mag_start = relative_count_next[REL_W-1]
                    ? {{(MAG_W-REL_W){1'b0}}, -relative_count_next}
                    : {{(MAG_W-REL_W){1'b0}}, relative_count_next};
        neg_start = relative_count_next[REL_W-1];
      end
      default: begin
        mag_start = delta_next[DELTA_W-1]
                    ? {{(MAG_W-DELTA_W){1'b0}}, -delta_next}
                    : {{(MAG_W-DELTA_W){1'b0}}, delta_next};
        neg_start = delta_next[DELTA_W-1];
      end
    endcase
  end

  // msb-first shift-add multiply and restoring divide step
  always_comb begin
    acc_next  = {acc[PROD_W-2:0], 1'b0} + (mul_b[SCALE_W-1] ? {{SCALE_W{1'b0}}, mul_a} : '0);
    div_trial = {rem, acc[PROD_W-1]};
    div_ge    = (div_trial >= SCALE_DIVISOR);
  end

  always_comb begin
    sum = {angle_acc[ANGLE_W-1], angle_acc} + {inc[ANGLE_W-1], inc};
    if (sum[ANGLE_W] != sum[ANGLE_W-1]) begin
      sum_sat = sum[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
    end else begin
      sum_sat = sum[ANGLE_W-1:0];
    end
    clamp_lo  = (pre <= angle_lo) ? angle_lo : pre;
    clamp_val = (clamp_lo >= angle_hi) ? angle_hi : clamp_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      enable         <= 1'b1;
      mode           <= MODE_ABS;
      step_angle     <= STEP_RST;
      angle_lo       <= START_RST;
      angle_hi       <= STOP_RST;
      scale_percent  <= SCALE_RST;
      last_position  <= '0;
      relative_count <= '0;
      last_delta     <= '0;
      angle_acc      <= '0;
      changed        <= 1'b0;
      out_valid      <= 1'b0;
      pass2          <= 1'b0;
      cnt            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE: enable        <= cfg_data[0];
          CFG_MODE:   mode          <= mode_t'(cfg_data[1:0]);
          CFG_STEP:   step_angle    <= cfg_data[STEP_W-1:0];
          CFG_START:  angle_lo      <= cfg_data;
          CFG_STOP:   angle_hi      <= cfg_data;
          CFG_SCALE:  scale_percent <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      // a reload in ST_FINISH takes care of the drain itself
      if (out_valid && m_axis_tready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (enable && (pos != last_position)) begin
              last_position  <= pos;
              relative_count <= relative_count_next;
              last_delta     <= delta_next;
              changed        <= 1'b1;
              mul_a          <= mag_start;
              mul_b          <= step_angle;
              neg            <= neg_start;
              acc            <= '0;
              pass2          <= 1'b0;
              cnt            <= CNT_W'(STEP_W - 1);
              state          <= (mode == MODE_HOLD) ? ST_FINISH : ST_MUL;
            end else begin
              changed <= 1'b0;
              state   <= ST_FINISH;
            end
          end
        end
        ST_MUL: begin
          if (cnt != '0) begin
            acc   <= acc_next;
            mul_b <= {mul_b[SCALE_W-2:0], 1'b0};
            cnt   <= cnt - 1'b1;
          end else if ((mode == MODE_SCALE) && !pass2) begin
            // second pass: (|delta| * step) * scale
            mul_a <= acc_next[MAG_W-1:0];
            mul_b <= scale_percent;
            acc   <= '0;
            pass2 <= 1'b1;
            cnt   <= CNT_W'(SCALE_W - 1);
          end else if (mode == MODE_SCALE) begin
            acc   <= acc_next;
            rem   <= '0;
            cnt   <= CNT_W'(PROD_W - 1);
            state <= ST_DIV;
          end else begin
            acc   <= acc_next;
            state <= ST_SAT;
          end
        end
        ST_DIV: begin
          // quotient bits enter from the bottom as dividend bits leave the top
          rem <= div_ge ? REM_W'(div_trial - SCALE_DIVISOR) : div_trial[REM_W-1:0];
          acc <= {acc[PROD_W-2:0], div_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (!neg) begin
            inc <= (acc > POS_LIMIT) ? ANGLE_MAX : acc[ANGLE_W-1:0];
          end else begin
            inc <= (acc > NEG_LIMIT) ? ANGLE_MIN : -acc[ANGLE_W-1:0];
          end
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          pre   <= (mode == MODE_SCALE) ? sum_sat : inc;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          angle_acc <= clamp_val;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_abs   <= last_position;
            out_rel   <= relative_count;
            out_delta <= last_delta;
            out_angle <= angle_acc;
            out_chg   <= changed;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_angle, out_delta, out_rel, out_abs};
  assign m_axis_tuser  = out_chg;

  // count only moves on an accepted word
  a_rel_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(relative_count))
    else $error("relative count changed without an accepted word");

  // a disabled block leaves the angle alone
  a_angle_disabled: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !enable) |=> $stable(angle_acc))
    else $error("angle changed while disabled");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= CNT_W'(SCALE_W - 1)))
    else $error("multiplier bit count out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < SCALE_DIVISOR))
    else $error("divider remainder not below divisor");

  a_clamp_window: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CLAMP) && (angle_lo <= angle_hi))
    |=> ((angle_acc >= angle_lo) && (angle_acc <= angle_hi)))
    else $error("clamped angle outside window");

endmodule
